>>> rtl/core/bcw_pkg.sv
// Shared types and constants of the bounded channel with waiters.
`default_nettype none
package bcw_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned ID_W = 8;
	localparam int unsigned CAP_W = 5;

	// Request kinds carried on the slave tuser bit.
	localparam logic CMD_SEND = 1'b0;
	localparam logic CMD_RECV = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_PARKED   = 2'd1,
		ST_REJECTED = 2'd2
	} status_t;

	// Push and pop strobes for the three queues of one request.
	typedef struct packed {
		logic               v_push;
		logic               v_pop;
		logic [VALUE_W-1:0] v_data;
		logic               s_push;
		logic               s_pop;
		logic               r_push;
		logic               r_pop;
	} queue_ctl_t;

	typedef struct packed {
		status_t            status;
		logic               recv_valid;
		logic [VALUE_W-1:0] recv_data;
		logic               wake_valid;
		logic [ID_W-1:0]    wake_id;
		logic               wake_is_receiver;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/core/bcw_fifo.sv
// Circular queue with a memory, a registered head word and a fill count.
`default_nettype none
module bcw_fifo #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic [WIDTH-1:0]               push_data,
	input  wire logic                           pop,
	output logic      [WIDTH-1:0]               head_data,
	output logic      [$clog2(DEPTH+1)-1:0]     count
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [AW-1:0]    head_n;
	logic [CW-1:0]    count_q;
	logic [WIDTH-1:0] head_data_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	assign head_n = pop ? wrap_inc(head_q) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_n;
			if (push) begin
				tail_q <= wrap_inc(tail_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// The next head word is fetched every cycle; a word written at that same
	// slot in this cycle is forwarded since the array still holds the old one.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
		if (push && (tail_q == head_n)) begin
			head_data_q <= push_data;
		end else begin
			head_data_q <= mem[head_n];
		end
	end

	assign head_data = head_data_q;
	assign count     = count_q;

endmodule
`default_nettype wire

>>> rtl/core/bcw_ctrl.sv
// Decision logic for one send or receive request against the queue heads and counts.
`default_nettype none
module bcw_ctrl #(
	parameter int unsigned VALUE_DEPTH  = 16,
	parameter int unsigned WAITER_DEPTH = 16
) (
	input  wire logic                                   cmd,
	input  wire logic [bcw_pkg::VALUE_W-1:0]            send_value,
	input  wire logic [$clog2(VALUE_DEPTH+1)-1:0]       cap,
	input  wire logic [$clog2(VALUE_DEPTH+1)-1:0]       v_count,
	input  wire logic [bcw_pkg::VALUE_W-1:0]            v_head,
	input  wire logic [$clog2(WAITER_DEPTH+1)-1:0]      s_count,
	input  wire logic [bcw_pkg::ID_W+bcw_pkg::VALUE_W-1:0] s_head,
	input  wire logic [$clog2(WAITER_DEPTH+1)-1:0]      r_count,
	input  wire logic [bcw_pkg::ID_W-1:0]               r_head,
	output bcw_pkg::queue_ctl_t                         ctl,
	output bcw_pkg::result_t                            res
);

	localparam int unsigned WCW = $clog2(WAITER_DEPTH + 1);

	logic v_empty;
	logic v_at_cap;
	logic s_full;
	logic s_empty;
	logic r_full;
	logic r_empty;

	assign v_empty  = (v_count == '0);
	assign v_at_cap = (v_count >= cap);
	assign s_full   = (s_count == WCW'(WAITER_DEPTH));
	assign s_empty  = (s_count == '0);
	assign r_full   = (r_count == WCW'(WAITER_DEPTH));
	assign r_empty  = (r_count == '0);

	always_comb begin
		ctl        = '0;
		res        = '0;
		res.status = bcw_pkg::ST_DONE;
		ctl.v_data = send_value;
		if (cmd == bcw_pkg::CMD_SEND) begin
			if (v_at_cap) begin
				if (s_full) begin
					res.status = bcw_pkg::ST_REJECTED;
				end else begin
					ctl.s_push = 1'b1;
					res.status = bcw_pkg::ST_PARKED;
				end
			end else if (v_empty && !r_empty) begin
				// Hand the value straight to the oldest parked receiver.
				ctl.r_pop            = 1'b1;
				res.recv_data        = send_value;
				res.wake_valid       = 1'b1;
				res.wake_id          = r_head;
				res.wake_is_receiver = 1'b1;
			end else begin
				ctl.v_push = 1'b1;
			end
		end else begin
			if (v_empty) begin
				if (r_full) begin
					res.status = bcw_pkg::ST_REJECTED;
				end else begin
					ctl.r_push = 1'b1;
					res.status = bcw_pkg::ST_PARKED;
				end
			end else begin
				ctl.v_pop      = 1'b1;
				res.recv_valid = 1'b1;
				res.recv_data  = v_head;
				if (v_at_cap && !s_empty) begin
					// The freed slot goes to the oldest parked sender.
					ctl.s_pop      = 1'b1;
					ctl.v_push     = 1'b1;
					ctl.v_data     = s_head[bcw_pkg::VALUE_W-1:0];
					res.wake_valid = 1'b1;
					res.wake_id    = s_head[bcw_pkg::ID_W+bcw_pkg::VALUE_W-1:bcw_pkg::VALUE_W];
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/bounded_channel_with_waiters_core.sv
// Top level of the bounded channel with parked senders and receivers.
//
// Usage: each request on the slave stream is a send (s_tuser = 0) carrying a
// value and a caller id, or a receive (s_tuser = 1) carrying a caller id. The
// channel buffers up to the configured capacity of values; a send that finds
// the buffer at capacity parks in the sender waiter queue, and a receive that
// finds it empty parks in the receiver waiter queue. Each request produces
// exactly one result on the master stream: the status in m_tuser, and in
// m_tdata the value returned or handed over and the id of any task woken.
// A request accepted at an edge has its result registered on m_tvalid after
// that edge. It takes one request per cycle unless the result stalls; only
// the decision and the head/tail pointer updates lie between the queue state
// registers and the result register. Each queue keeps its head word in a
// register refetched from the queue memory every cycle. A stalled receiver
// holds the result register; s_tready stays high as long as the result
// register is empty or being drained in the same cycle. Reset empties all
// three queues and sets the capacity to one. The user must write the capacity
// register through cfg_we/cfg_wdata only while the channel is idle; the block
// does not enforce it. Zero acts as one and values above VALUE_DEPTH saturate.
`default_nettype none
module bounded_channel_with_waiters_core #(
	parameter int unsigned VALUE_DEPTH  = 16,
	parameter int unsigned WAITER_DEPTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [bcw_pkg::CAP_W-1:0]   cfg_wdata,    // queue_capacity
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [39:0]                 s_tdata,      // send_value[31:0], caller_id[39:32]
	input  wire logic                        s_tuser,      // command
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [47:0]                      m_tdata,      // recv_valid[0], recv_data[32:1],
	                                                       // wake_valid[33], wake_id[41:34],
	                                                       // wake_is_receiver[42], zero[47:43]
	output logic [1:0]                       m_tuser       // status
);

	localparam int unsigned CW  = $clog2(VALUE_DEPTH + 1);
	localparam int unsigned WCW = $clog2(WAITER_DEPTH + 1);
	localparam int unsigned VW  = bcw_pkg::VALUE_W;
	localparam int unsigned IW  = bcw_pkg::ID_W;

	logic                 accept;
	logic [CW-1:0]        cap_q;
	logic [CW-1:0]        v_count;
	logic [VW-1:0]        v_head;
	logic [WCW-1:0]       s_count;
	logic [IW+VW-1:0]     s_head;
	logic [WCW-1:0]       r_count;
	logic [IW-1:0]        r_head;
	bcw_pkg::queue_ctl_t  ctl;
	bcw_pkg::result_t     res;
	logic                 out_valid_q;
	logic [47:0]          out_data_q;
	logic [1:0]           out_user_q;

	// A new request is taken whenever the result register is free or drains now.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// The capacity is clamped when written so the decision sees a legal value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(1);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				cap_q <= CW'(1);
			end else if (32'(cfg_wdata) > VALUE_DEPTH) begin
				cap_q <= CW'(VALUE_DEPTH);
			end else begin
				cap_q <= CW'(cfg_wdata);
			end
		end
	end

	bcw_ctrl #(
		.VALUE_DEPTH (VALUE_DEPTH),
		.WAITER_DEPTH(WAITER_DEPTH)
	) u_ctrl (
		.cmd       (s_tuser),
		.send_value(s_tdata[VW-1:0]),
		.cap       (cap_q),
		.v_count   (v_count),
		.v_head    (v_head),
		.s_count   (s_count),
		.s_head    (s_head),
		.r_count   (r_count),
		.r_head    (r_head),
		.ctl       (ctl),
		.res       (res)
	);

	// Buffered values.
	bcw_fifo #(
		.WIDTH(VW),
		.DEPTH(VALUE_DEPTH)
	) u_value_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && ctl.v_push),
		.push_data(ctl.v_data),
		.pop      (accept && ctl.v_pop),
		.head_data(v_head),
		.count    (v_count)
	);

	// Parked senders: caller id above the value they offered.
	bcw_fifo #(
		.WIDTH(IW + VW),
		.DEPTH(WAITER_DEPTH)
	) u_sender_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && ctl.s_push),
		.push_data(s_tdata[IW+VW-1:0]),
		.pop      (accept && ctl.s_pop),
		.head_data(s_head),
		.count    (s_count)
	);

	// Parked receivers: caller id only.
	bcw_fifo #(
		.WIDTH(IW),
		.DEPTH(WAITER_DEPTH)
	) u_receiver_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && ctl.r_push),
		.push_data(s_tdata[IW+VW-1:VW]),
		.pop      (accept && ctl.r_pop),
		.head_data(r_head),
		.count    (r_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {5'b0, res.wake_is_receiver, res.wake_id, res.wake_valid,
				res.recv_data, res.recv_valid};
			out_user_q <= 2'(res.status);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
`default_nettype wire

>>> rtl/core/bcw_checker.sv
// Port-level checker for the channel core, with its bind to the top level.
`default_nettype none
module bcw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [1:0]  m_tuser
);

	localparam int unsigned RECV_VALID_BIT = 0;
	localparam int unsigned WAKE_VALID_BIT = 33;
	localparam int unsigned WAKE_RECV_BIT  = 42;

	// The input side only stalls behind a held result.
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("s_tready low without a stalled result");

	// Every accepted request shows a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted request produced no result");

	// Parked or rejected requests neither return a value nor wake anyone.
	a_park_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != bcw_pkg::ST_DONE)) |->
		(!m_tdata[RECV_VALID_BIT] && !m_tdata[WAKE_VALID_BIT]))
		else $error("parked or rejected result carries a value or wake");

	// Waking a receiver happens only on a send, which never returns a value itself.
	a_recv_wake_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[WAKE_RECV_BIT]) |->
		(m_tdata[WAKE_VALID_BIT] && !m_tdata[RECV_VALID_BIT]))
		else $error("receiver wake without wake_valid or with recv_valid");

	// A stalled result holds still.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

endmodule

bind bounded_channel_with_waiters_core bcw_checker u_bcw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
`default_nettype wire

>>> sim/bounded_channel_with_waiters_core_tb.sv
// Self-checking testbench for the bounded channel with parked senders and receivers.
`default_nettype none
module bounded_channel_with_waiters_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VALUE_SLOTS  = 16;
	localparam int unsigned WAITER_SLOTS = 16;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned PHASE_ITEMS  = 92;
	localparam int unsigned PHASE_COUNT  = 12;

	// A parked sender keeps both its value and its id.
	typedef struct packed {
		logic [bcw_pkg::VALUE_W-1:0] value;
		logic [bcw_pkg::ID_W-1:0]    id;
	} parked_sender_t;

	// Mirror of the channel state. Every accepted request is applied to the
	// mirror at once, and the result it must produce is queued in order.
	class channel_scoreboard;
		int unsigned                 capacity;
		logic [bcw_pkg::VALUE_W-1:0] buffered[$];
		parked_sender_t              senders[$];
		logic [bcw_pkg::ID_W-1:0]    receivers[$];
		bcw_pkg::result_t            pending[$];
		int                          errors;

		function new();
			capacity = 1;
			errors = 0;
		endfunction

		function void set_capacity(input logic [bcw_pkg::CAP_W-1:0] cap);
			capacity = cap;
		endfunction

		// A stored capacity of zero behaves as one and large values saturate.
		function int unsigned usable_capacity();
			if (capacity == 0)
				return 1;
			if (capacity > VALUE_SLOTS)
				return VALUE_SLOTS;
			return capacity;
		endfunction

		function void note_request(input logic cmd, input logic [bcw_pkg::VALUE_W-1:0] val,
		                           input logic [bcw_pkg::ID_W-1:0] id);
			bcw_pkg::result_t r;
			parked_sender_t   ps;
			int unsigned      cap;
			logic             was_full;
			r = '0;
			r.status = bcw_pkg::ST_DONE;
			cap = usable_capacity();
			if (cmd == bcw_pkg::CMD_SEND) begin
				if (buffered.size() >= cap) begin
					if (senders.size() >= WAITER_SLOTS) begin
						r.status = bcw_pkg::ST_REJECTED;
					end else begin
						ps.value = val;
						ps.id = id;
						senders.insert(senders.size(), ps);
						r.status = bcw_pkg::ST_PARKED;
					end
				end else if (buffered.size() == 0 && receivers.size() > 0) begin
					// Direct hand-over to the oldest parked receiver.
					r.wake_id = receivers[0];
					receivers.delete(0);
					r.recv_data = val;
					r.wake_valid = 1'b1;
					r.wake_is_receiver = 1'b1;
				end else begin
					buffered.insert(buffered.size(), val);
				end
			end else begin
				if (buffered.size() == 0) begin
					if (receivers.size() >= WAITER_SLOTS) begin
						r.status = bcw_pkg::ST_REJECTED;
					end else begin
						receivers.insert(receivers.size(), id);
						r.status = bcw_pkg::ST_PARKED;
					end
				end else begin
					// The fill is compared before the pop, so a buffer left above a
					// lowered capacity still counts as full here.
					was_full = buffered.size() >= cap;
					r.recv_data = buffered[0];
					buffered.delete(0);
					r.recv_valid = 1'b1;
					if (was_full && senders.size() > 0) begin
						ps = senders[0];
						senders.delete(0);
						buffered.insert(buffered.size(), ps.value);
						r.wake_valid = 1'b1;
						r.wake_id = ps.id;
						r.wake_is_receiver = 1'b0;
					end
				end
			end
			pending.insert(pending.size(), r);
		endfunction

		function void compare_field(input string name, input logic [31:0] want,
		                            input logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input logic [1:0] status, input logic [47:0] data);
			bcw_pkg::result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d data %h",
				         $realtime, status, data);
				errors++;
				return;
			end
			want = pending[0];
			pending.delete(0);
			compare_field("status", 32'(want.status), 32'(status));
			compare_field("recv_valid", 32'(want.recv_valid), 32'(data[0]));
			compare_field("recv_data", want.recv_data, data[32:1]);
			compare_field("wake_valid", 32'(want.wake_valid), 32'(data[33]));
			compare_field("wake_id", 32'(want.wake_id), 32'(data[41:34]));
			compare_field("wake_is_receiver", 32'(want.wake_is_receiver), 32'(data[42]));
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [bcw_pkg::CAP_W-1:0]   cfg_wdata = '0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [39:0]                 s_tdata = '0;      // send_value[31:0], caller_id[39:32]
	logic                        s_tuser = 1'b0;    // command
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [47:0]                 m_tdata;           // recv_valid[0], recv_data[32:1],
	                                                // wake_valid[33], wake_id[41:34],
	                                                // wake_is_receiver[42], zero[47:43]
	logic [1:0]                  m_tuser;           // status

	channel_scoreboard  sb = new();
	int unsigned        idle_pct = 0;
	int unsigned        stall_pct = 0;
	int unsigned        hold_left = 0;

	bounded_channel_with_waiters_core #(
		.VALUE_DEPTH(VALUE_SLOTS),
		.WAITER_DEPTH(WAITER_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver side. A requested hold-off keeps tready low for a counted
	// stretch; otherwise tready stalls at the rate of the current phase.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready = ($urandom_range(99) >= stall_pct);
		end
	end

	// Both handshakes are observed at the rising edge. A request is mirrored
	// when accepted; its result can only show up at a later edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[31:0], s_tdata[39:32]);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
		end
	end

	// Offers one request, entered and left at a falling edge. Idle cycles in
	// front of it carry junk on the data lines with tvalid low.
	task automatic offer_request(input logic cmd, input logic [bcw_pkg::VALUE_W-1:0] val,
	                             input logic [bcw_pkg::ID_W-1:0] id);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			s_tdata = {8'($urandom), 32'($urandom)};
			s_tuser = 1'($urandom);
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {id, val};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic random_request(input int unsigned send_pct);
		logic                        cmd;
		logic [bcw_pkg::VALUE_W-1:0] val;
		cmd = ($urandom_range(99) < send_pct) ? bcw_pkg::CMD_SEND : bcw_pkg::CMD_RECV;
		case ($urandom_range(15))
			0: val = 32'h8000_0000;
			1: val = 32'h7FFF_FFFF;
			2: val = 32'h0000_0000;
			3: val = 32'hFFFF_FFFF;
			default: val = $urandom;
		endcase
		offer_request(cmd, val, 8'($urandom_range(255)));
	endtask

	// Lowers tvalid and waits until every accepted request has its result.
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Only called while the channel is idle.
	task automatic set_capacity(input logic [bcw_pkg::CAP_W-1:0] cap);
		cfg_we = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_capacity(cap);
	endtask

	initial begin
		logic [bcw_pkg::CAP_W-1:0] cap;
		int unsigned               send_pct;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset capacity of one. Seventeen receives on an
		// empty channel fill the receiver waiter queue and the last one is
		// rejected; the sends with extreme values are then handed straight to
		// the oldest parked receivers.
		for (int i = 0; i < 17; i++)
			offer_request(bcw_pkg::CMD_RECV, 32'h5A5A_5A5A,
			              (i == 0) ? 8'h00 : 8'(255 - i * 15));
		offer_request(bcw_pkg::CMD_SEND, 32'h8000_0000, 8'h00);
		offer_request(bcw_pkg::CMD_SEND, 32'h7FFF_FFFF, 8'hFF);
		offer_request(bcw_pkg::CMD_SEND, 32'h0000_0000, 8'h01);
		offer_request(bcw_pkg::CMD_SEND, 32'hFFFF_FFFF, 8'h80);

		// Random phases. The capacity sequence includes zero, the saturating
		// values and a drop from sixteen to zero while the buffer is loaded, so
		// the channel sits above its capacity. Send-heavy phases fill the sender
		// waiter queue and receive-heavy phases the receiver waiter queue.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			case (p)
				0: cap = 5'd16;
				1: cap = 5'd0;
				2: cap = 5'd31;
				3: cap = 5'd4;
				4: cap = 5'd1;
				5: cap = 5'd2;
				6: cap = 5'd17;
				7: cap = 5'd8;
				8: cap = 5'd16;
				9: cap = 5'd3;
				10: cap = 5'd1;
				default: cap = 5'($urandom_range(31));
			endcase
			set_capacity(cap);
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 84; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 84; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			case (p % 3)
				0: send_pct = 75;
				1: send_pct = 35;
				default: send_pct = 55;
			endcase
			// Hold the receiver off while requests keep coming every cycle, so
			// the result register fills and the input stalls.
			if (p % 4 == 0 && p > 0) begin
				@(posedge clk);
				hold_left = HOLD_CYCLES;
				@(negedge clk);
			end
			repeat (PHASE_ITEMS) random_request(send_pct);
		end

		drain_results();
		repeat (5) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
